/* design/scsa_pkg.sv */
package scsa_pkg;

    localparam int MAX_CLASSES_DEF     = 4;
    localparam int NUM_PAGES_DEF       = 16;
    localparam int PAGE_DATA_BYTES_DEF = 4088;
    localparam int FREE_DEPTH_DEF      = 64;

    // number of class size registers on the configuration port
    localparam int SIZE_REGS = 4;

    // stored free-list entry: page in the upper nibble, offset below
    localparam int ENTRY_W = 16;

    localparam int CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_CLASS_COUNT  = 3'd0,
        REG_CLASS_SIZE_0 = 3'd1,
        REG_CLASS_SIZE_1 = 3'd2,
        REG_CLASS_SIZE_2 = 3'd3,
        REG_CLASS_SIZE_3 = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_REUSED        = 4'd0,
        ST_CARVED        = 4'd1,
        ST_FRESH_PAGE    = 4'd2,
        ST_NO_CLASS      = 4'd3,
        ST_EXHAUSTED     = 4'd4,
        ST_FREED         = 4'd5,
        ST_FREED_GENERAL = 4'd6,
        ST_NULL_IGNORED  = 4'd7,
        ST_LIST_FULL     = 4'd8
    } status_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

/* design/size_class_slab_allocator.sv */
// Size-class slab allocator.
// Input channel (in_valid/in_stall) carries one alloc or free transaction;
// output channel (out_valid/out_stall) returns exactly one result per input.
// A transaction is taken at a rising edge with valid high and stall low.
// An accepted input is latched into the transaction registers, processed in
// the lookup state, and its result is loaded into the output register. The
// lookup pops or pushes the stack entry in the free-list memory as needed.
// No input is taken during lookup; the next one is taken in the cycle the
// previous result leaves. While out_stall holds a result, in_stall is
// raised and nothing is lost; the result holds steady until taken.
// Size classes are set over the APB port (class_count at 0x0, class sizes at
// 0x4..0x10); the user must write them only while the block is idle, unchecked.
// Reset (rst_n low, asynchronous) empties all free lists, parks every class
// on a full page so the first alloc takes a fresh one, and resets the page
// counter. The free-list memory is not cleared and needs no clearing pass.
module size_class_slab_allocator
    import scsa_pkg::*;
#(
    parameter int MAX_CLASSES     = MAX_CLASSES_DEF,
    parameter int NUM_PAGES       = NUM_PAGES_DEF,
    parameter int PAGE_DATA_BYTES = PAGE_DATA_BYTES_DEF,
    parameter int FREE_DEPTH      = FREE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [15:0]           request_size,
    input  logic [3:0]            page_index,
    input  logic [11:0]           block_offset,
    input  logic                  pointer_null,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            status,
    output logic [3:0]            result_page,
    output logic [11:0]           result_offset,
    output logic [1:0]            class_index
);

    localparam int NCLS   = (MAX_CLASSES < SIZE_REGS) ? MAX_CLASSES : SIZE_REGS;
    localparam int CLS_W  = (NCLS > 1) ? $clog2(NCLS) : 1;
    localparam int TOP_W  = $clog2(FREE_DEPTH + 1);
    localparam int FI_W   = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int AW     = CLS_W + FI_W;
    localparam int MEM_DEPTH = 2 ** AW;
    localparam int FILL_W = $clog2(PAGE_DATA_BYTES + 1);
    localparam int NP_W   = $clog2(NUM_PAGES + 1);
    localparam int PG_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOOKUP = 2'b10
    } state_t;

    // configuration
    logic [2:0] class_count_reg;
    logic [5:0] class_size_reg [SIZE_REGS];
    logic       cfg_write;
    logic [2:0] cfg_index;

    // control and per-class state
    state_t            state_reg, state_next;
    logic [TOP_W-1:0]  free_top_reg  [NCLS];
    logic [TOP_W-1:0]  free_top_next [NCLS];
    logic [PG_W-1:0]   cur_page_reg  [NCLS];
    logic [PG_W-1:0]   cur_page_next [NCLS];
    logic [FILL_W-1:0] fill_reg      [NCLS];
    logic [FILL_W-1:0] fill_next     [NCLS];
    logic [NP_W-1:0]   next_page_reg, next_page_next;

    // latched transaction
    logic        cmd_reg;
    logic [15:0] size_reg;
    logic [3:0]  pg_in_reg;
    logic [11:0] off_in_reg;
    logic        null_reg;

    // free-list memory
    logic [ENTRY_W-1:0] stack_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic               mem_re;

    // output register
    logic        out_valid_reg;
    logic        pop_reg;
    status_t     status_reg;
    logic [3:0]  page_reg;
    logic [11:0] offset_reg;
    logic [1:0]  class_reg;

    // lookup results
    logic              in_accept;
    logic              lookup_done;
    logic [2:0]        in_use;
    logic              found;
    logic [CLS_W-1:0]  ci;
    logic [5:0]        blk;
    logic [TOP_W-1:0]  top;
    logic [TOP_W-1:0]  top_dec;
    logic [FILL_W:0]   fill_sum;
    status_t           status_next;
    logic [3:0]        page_next;
    logic [11:0]       offset_next;
    logic [1:0]        class_next;
    logic              pop_next;

    // ---------------------------------------------------------------
    // APB
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_comb
    begin
        prdata = 32'd0;
        unique case (cfg_index)
            REG_CLASS_COUNT:  prdata = {29'd0, class_count_reg};
            REG_CLASS_SIZE_0: prdata = {26'd0, class_size_reg[0]};
            REG_CLASS_SIZE_1: prdata = {26'd0, class_size_reg[1]};
            REG_CLASS_SIZE_2: prdata = {26'd0, class_size_reg[2]};
            REG_CLASS_SIZE_3: prdata = {26'd0, class_size_reg[3]};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg   <= 3'd1;
            class_size_reg[0] <= 6'd8;
            class_size_reg[1] <= 6'd16;
            class_size_reg[2] <= 6'd32;
            class_size_reg[3] <= 6'd48;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CLASS_COUNT:  class_count_reg   <= pwdata[2:0];
                REG_CLASS_SIZE_0: class_size_reg[0] <= pwdata[5:0];
                REG_CLASS_SIZE_1: class_size_reg[1] <= pwdata[5:0];
                REG_CLASS_SIZE_2: class_size_reg[2] <= pwdata[5:0];
                REG_CLASS_SIZE_3: class_size_reg[3] <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    // output register is free by the end of the lookup cycle
    assign in_stall    = (state_reg == S_LOOKUP) || (out_valid_reg && out_stall);
    assign in_accept   = in_valid && !in_stall;
    assign lookup_done = (state_reg == S_LOOKUP);

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign result_page   = pop_reg ? rd_data_reg[15:12] : page_reg;
    assign result_offset = pop_reg ? rd_data_reg[11:0]  : offset_reg;
    assign class_index   = class_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_accept) state_next = S_LOOKUP;
            S_LOOKUP: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg    <= command;
            size_reg   <= request_size;
            pg_in_reg  <= page_index;
            off_in_reg <= block_offset;
            null_reg   <= pointer_null;
        end
    end

    // ---------------------------------------------------------------
    // Class search and update
    // ---------------------------------------------------------------
    assign in_use = (class_count_reg > 3'(NCLS)) ? 3'(NCLS) : class_count_reg;

    always_comb
    begin
        found = 1'b0;
        ci    = '0;
        // scan downwards so the fitting class with the lowest index wins
        for (int i = SIZE_REGS - 1; i >= 0; i--)
        begin
            if (i < NCLS && 3'(i) < in_use && class_size_reg[i] != 6'd0
                && {10'd0, class_size_reg[i]} >= size_reg)
            begin
                found = 1'b1;
                ci    = CLS_W'(i);
            end
        end
    end

    assign blk      = class_size_reg[ci];
    assign top      = free_top_reg[ci];
    assign top_dec  = top - TOP_W'(1);
    assign fill_sum = {1'b0, fill_reg[ci]} + (FILL_W + 1)'(blk);

    always_comb
    begin
        for (int k = 0; k < NCLS; k++)
        begin
            free_top_next[k] = free_top_reg[k];
            cur_page_next[k] = cur_page_reg[k];
            fill_next[k]     = fill_reg[k];
        end
        next_page_next = next_page_reg;
        status_next    = ST_NO_CLASS;
        page_next      = 4'd0;
        offset_next    = 12'd0;
        class_next     = 2'd0;
        pop_next       = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = {ci, top[FI_W-1:0]};

        if (lookup_done)
        begin
            if (cmd_reg == CMD_ALLOC)
            begin
                if (!found)
                begin
                    status_next = ST_NO_CLASS;
                end
                else if (top != '0)
                begin
                    status_next       = ST_REUSED;
                    class_next        = 2'(ci);
                    pop_next          = 1'b1;
                    mem_re            = 1'b1;
                    mem_addr          = {ci, top_dec[FI_W-1:0]};
                    free_top_next[ci] = top_dec;
                end
                else if (fill_sum > (FILL_W + 1)'(PAGE_DATA_BYTES))
                begin
                    class_next = 2'(ci);
                    if (next_page_reg >= NP_W'(NUM_PAGES))
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        status_next       = ST_FRESH_PAGE;
                        page_next         = 4'(next_page_reg);
                        cur_page_next[ci] = next_page_reg[PG_W-1:0];
                        fill_next[ci]     = FILL_W'(blk);
                        next_page_next    = next_page_reg + NP_W'(1);
                    end
                end
                else
                begin
                    status_next   = ST_CARVED;
                    class_next    = 2'(ci);
                    page_next     = 4'(cur_page_reg[ci]);
                    offset_next   = 12'(fill_reg[ci]);
                    fill_next[ci] = fill_sum[FILL_W-1:0];
                end
            end
            else if (null_reg)
            begin
                status_next = ST_NULL_IGNORED;
            end
            else if (!found)
            begin
                status_next = ST_FREED_GENERAL;
            end
            else if (top >= TOP_W'(FREE_DEPTH))
            begin
                status_next = ST_LIST_FULL;
                class_next  = 2'(ci);
            end
            else
            begin
                status_next       = ST_FREED;
                class_next        = 2'(ci);
                mem_we            = 1'b1;
                free_top_next[ci] = top + TOP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_addr] <= {pg_in_reg, off_in_reg};
        if (mem_re)
            rd_data_reg <= stack_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_page_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NCLS; k++)
            begin
                free_top_reg[k] <= '0;
                cur_page_reg[k] <= '0;
                fill_reg[k]     <= FILL_W'(PAGE_DATA_BYTES);
            end
        end
        else
        begin
            state_reg     <= state_next;
            next_page_reg <= next_page_next;
            for (int k = 0; k < NCLS; k++)
            begin
                free_top_reg[k] <= free_top_next[k];
                cur_page_reg[k] <= cur_page_next[k];
                fill_reg[k]     <= fill_next[k];
            end
            if (lookup_done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_done)
        begin
            status_reg <= status_next;
            page_reg   <= page_next;
            offset_reg <= offset_next;
            class_reg  <= class_next;
            pop_reg    <= pop_next;
        end
    end

endmodule

/* tb/tb_size_class_slab_allocator.sv */
`timescale 1ns / 100ps

import scsa_pkg::*;

typedef struct {
    logic        cmd;
    logic [15:0] size;
    logic [3:0]  page;
    logic [11:0] offs;
    logic        is_null;
} slab_req_t;

typedef struct {
    status_t     st;
    logic [3:0]  page;
    logic [11:0] offs;
    logic [1:0]  cls;
} slab_res_t;

typedef struct {
    logic [3:0]  page;
    logic [11:0] offs;
    logic [15:0] size;
} live_block_t;

// Mirror of the allocator: class settings, free lists, page carving and the
// results still owed by the block.
class slab_ledger;
    logic [2:0]         class_count;
    logic [5:0]         class_size[SIZE_REGS];
    logic [ENTRY_W-1:0] free_list[MAX_CLASSES_DEF][FREE_DEPTH_DEF];
    int                 free_top[MAX_CLASSES_DEF];
    logic [3:0]         cur_page[MAX_CLASSES_DEF];
    int                 fill_pos[MAX_CLASSES_DEF];
    int                 pages_handed;
    slab_res_t          pending_results[$];
    live_block_t        live_blocks[$];
    int                 failures;
    int                 results_taken;
    int                 seen[16];

    function new();
        class_count = 3'd1;
        class_size = '{6'd8, 6'd16, 6'd32, 6'd48};
        for (int i = 0; i < MAX_CLASSES_DEF; i++)
        begin
            free_top[i] = 0;
            cur_page[i] = '0;
            fill_pos[i] = PAGE_DATA_BYTES_DEF;
        end
        pages_handed = 0;
        failures = 0;
        results_taken = 0;
        foreach (seen[i])
            seen[i] = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] value);
        if (idx == REG_CLASS_COUNT)
            class_count = value[2:0];
        else
            class_size[int'(idx) - 1] = value[5:0];
    endfunction

    function int first_fit(logic [15:0] size);
        int n;
        n = (class_count > MAX_CLASSES_DEF) ? MAX_CLASSES_DEF : int'(class_count);
        if (n > SIZE_REGS)
            n = SIZE_REGS;
        for (int i = 0; i < n; i++)
            if (class_size[i] != 0 && class_size[i] >= size)
                return i;
        return -1;
    endfunction

    // Works out the outcome of an accepted transaction and queues it.
    function void note_request(slab_req_t r);
        slab_res_t exp;
        int        c;
        exp = '{ST_NO_CLASS, 4'd0, 12'd0, 2'd0};
        c = first_fit(r.size);
        if (r.cmd == CMD_ALLOC)
        begin
            if (c >= 0)
            begin
                exp.cls = c[1:0];
                if (free_top[c] > 0)
                begin
                    free_top[c]--;
                    exp.st = ST_REUSED;
                    {exp.page, exp.offs} = free_list[c][free_top[c]];
                end
                else if (fill_pos[c] + class_size[c] > PAGE_DATA_BYTES_DEF)
                begin
                    if (pages_handed >= NUM_PAGES_DEF)
                        exp.st = ST_EXHAUSTED;
                    else
                    begin
                        cur_page[c] = pages_handed[3:0];
                        pages_handed++;
                        fill_pos[c] = class_size[c];
                        exp.st = ST_FRESH_PAGE;
                        exp.page = cur_page[c];
                    end
                end
                else
                begin
                    exp.st = ST_CARVED;
                    exp.page = cur_page[c];
                    exp.offs = fill_pos[c][11:0];
                    fill_pos[c] += class_size[c];
                end
                if (exp.st inside {ST_REUSED, ST_CARVED, ST_FRESH_PAGE})
                begin
                    live_blocks.push_back('{exp.page, exp.offs, r.size});
                    if (live_blocks.size() > 256)
                        void'(live_blocks.pop_front());
                end
            end
        end
        else if (r.is_null)
            exp.st = ST_NULL_IGNORED;
        else if (c < 0)
            exp.st = ST_FREED_GENERAL;
        else
        begin
            exp.cls = c[1:0];
            if (free_top[c] >= FREE_DEPTH_DEF)
                exp.st = ST_LIST_FULL;
            else
            begin
                free_list[c][free_top[c]] = {r.page, r.offs};
                free_top[c]++;
                exp.st = ST_FREED;
            end
        end
        pending_results.push_back(exp);
    endfunction

    function bit take_live(output live_block_t b);
        int k;
        if (live_blocks.size() == 0)
            return 0;
        k = $urandom_range(0, live_blocks.size() - 1);
        b = live_blocks[k];
        live_blocks.delete(k);
        return 1;
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    function void check_result(slab_res_t got);
        slab_res_t exp;
        results_taken++;
        if (!$isunknown(got.st))
            seen[got.st]++;
        if (pending_results.size() == 0)
        begin
            flag($sformatf("unexpected result: status %0d page %0d offset %0d class %0d",
                           got.st, got.page, got.offs, got.cls));
            return;
        end
        exp = pending_results.pop_front();
        if (got.st !== exp.st || got.page !== exp.page || got.offs !== exp.offs
                || got.cls !== exp.cls)
            flag($sformatf({"result %0d: expected %s page %0d offset %0d class %0d,",
                            " got status %0d page %0d offset %0d class %0d"},
                           results_taken, exp.st.name(), exp.page, exp.offs, exp.cls,
                           got.st, got.page, got.offs, got.cls));
    endfunction
endclass

module tb_size_class_slab_allocator;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  command = CMD_ALLOC;
    logic [15:0]           request_size = '0;
    logic [3:0]            page_index = '0;
    logic [11:0]           block_offset = '0;
    logic                  pointer_null = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [3:0]            status;
    logic [3:0]            result_page;
    logic [11:0]           result_offset;
    logic [1:0]            class_index;

    slab_ledger ledger = new();
    bit         tx_idle = 1'b1;
    bit         rx_idle = 1'b1;
    bit         hold_off_req = 1'b0;
    int         settings_used = 0;

    size_class_slab_allocator i_dut (.*);

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            ledger.check_result('{status_t'(status), result_page, result_offset, class_index});
    end

    function automatic int idle_draw(bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Receiver: random stall after each result, plus one long hold-off on request
    initial
    begin : receiver
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (out_valid === 1'b1 && !out_stall)
            begin
                n = idle_draw(rx_idle);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic apb_access(logic wr, reg_index_t idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(int count, int s0, int s1, int s2, int s3);
        logic [31:0] vals[5];
        logic [31:0] rd;
        logic [31:0] mask;
        reg_index_t  idx;
        vals = '{count, s0, s1, s2, s3};
        for (int i = 0; i < 5; i++)
        begin
            idx = reg_index_t'(i);
            apb_access(1'b1, idx, vals[i], rd);
            ledger.write_reg(idx, vals[i]);
        end
        for (int i = 0; i < 5; i++)
        begin
            idx = reg_index_t'(i);
            apb_access(1'b0, idx, 32'd0, rd);
            mask = (idx == REG_CLASS_COUNT) ? 32'h7 : 32'h3f;
            if ((rd & mask) !== (vals[i] & mask))
                ledger.flag($sformatf("readback of %s: expected %0d, got %0d",
                                      idx.name(), vals[i] & mask, rd & mask));
        end
        settings_used++;
    endtask

    function automatic slab_req_t req(logic cmd, int size, int page, int offs, logic nul);
        return '{cmd, 16'(size), 4'(page), 12'(offs), nul};
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return 16'($urandom_range(64, 65535));
            default: return 16'($urandom_range(1, 64));
        endcase
    endfunction

    // alloc_pct sets allocs; frees mostly of blocks handed out earlier, else noise
    function automatic slab_req_t make_req(int alloc_pct);
        slab_req_t   r;
        live_block_t b;
        r.cmd = ($urandom_range(1, 100) <= alloc_pct) ? CMD_ALLOC : CMD_FREE;
        r.size = pick_size();
        r.page = 4'($urandom);
        r.offs = 12'($urandom);
        r.is_null = ($urandom_range(0, 9) == 0);
        if (r.cmd == CMD_FREE && $urandom_range(0, 4) != 0 && ledger.take_live(b))
        begin
            r.size = b.size;
            r.page = b.page;
            r.offs = b.offs;
            r.is_null = 1'b0;
        end
        return r;
    endfunction

    task automatic send_req(slab_req_t r);
        int gap;
        in_valid <= 1'b1;
        command <= r.cmd;
        request_size <= r.size;
        page_index <= r.page;
        block_offset <= r.offs;
        pointer_null <= r.is_null;
        do @(posedge clk); while (in_stall);
        ledger.note_request(r);
        gap = idle_draw(tx_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_random(int count, int alloc_pct);
        repeat (count) send_req(make_req(alloc_pct));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (ledger.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(4, 1, 16, 32, 63);
        send_req(req(CMD_ALLOC, 0, 0, 0, 1'b0));
        send_req(req(CMD_ALLOC, 1, 15, 4095, 1'b1));
        send_req(req(CMD_ALLOC, 63, 0, 0, 1'b0));
        send_req(req(CMD_ALLOC, 64, 0, 0, 1'b0));
        send_req(req(CMD_ALLOC, 65535, 0, 0, 1'b0));
        send_req(req(CMD_FREE, 0, 15, 4095, 1'b1));
        send_req(req(CMD_FREE, 65535, 15, 4095, 1'b0));
        send_req(req(CMD_FREE, 63, 15, 4095, 1'b0));
        send_req(req(CMD_ALLOC, 40, 0, 0, 1'b0));
        send_req(req(CMD_ALLOC, 17, 0, 0, 1'b0));
        send_req(req(CMD_ALLOC, 16, 0, 0, 1'b0));
        send_req(req(CMD_FREE, 2, 0, 0, 1'b0));
        send_req(req(CMD_ALLOC, 9, 0, 0, 1'b0));
        send_req(req(CMD_FREE, 1, 3, 8, 1'b1));
        settle();

        // no class in use: everything belongs to the general allocator
        configure(0, 1, 16, 32, 63);
        send_req(req(CMD_ALLOC, 1, 0, 0, 1'b0));
        send_req(req(CMD_FREE, 1, 5, 10, 1'b0));
        settle();

        // count saturates; zero-size class never fits; sizes out of order
        configure(7, 0, 5, 3, 63);
        send_req(req(CMD_ALLOC, 0, 0, 0, 1'b0));
        send_req(req(CMD_ALLOC, 4, 0, 0, 1'b0));
        send_req(req(CMD_ALLOC, 6, 0, 0, 1'b0));
        send_req(req(CMD_FREE, 3, 9, 100, 1'b0));
        send_req(req(CMD_ALLOC, 5, 0, 0, 1'b0));
        settle();

        configure(4, 8, 16, 32, 48);
        run_random(300, 55);
        settle();

        // free-heavy single class fills its list; receiver holds off meanwhile
        configure(1, 20, 16, 32, 48);
        hold_off_req = 1'b1;
        tx_idle = 1'b0;
        run_random(250, 20);
        tx_idle = 1'b1;
        settle();

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        configure(3, 40, 0, 12, 48);
        run_random(250, 50);
        settle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        configure(0, 8, 16, 32, 48);
        run_random(60, 50);
        settle();

        // large blocks drain the page pool
        configure(7, 63, 63, 1, 5);
        run_random(800, 95);
        settle();

        configure(4, 1, 2, 3, 4);
        run_random(150, 50);
        settle();
        repeat (10) @(posedge clk);

        $display("Covered %0d transactions over %0d class settings: ", ledger.results_taken,
                 settings_used, "%0d reused, %0d carved, %0d fresh pages, ",
                 ledger.seen[ST_REUSED], ledger.seen[ST_CARVED], ledger.seen[ST_FRESH_PAGE],
                 "%0d unclassed, %0d on exhausted pool.", ledger.seen[ST_NO_CLASS],
                 ledger.seen[ST_EXHAUSTED]);
        $display("Frees: %0d listed, %0d general, %0d null, %0d dropped; %0d mismatches.",
                 ledger.seen[ST_FREED], ledger.seen[ST_FREED_GENERAL],
                 ledger.seen[ST_NULL_IGNORED], ledger.seen[ST_LIST_FULL], ledger.failures);
        if (ledger.failures == 0 && ledger.pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
